[design/cbie_pkg.sv]
// Shared types and constants for the CBOR item head encoder.
package cbie_pkg;

    // Input opcodes
    localparam logic [2:0] OP_UINT    = 3'd0;
    localparam logic [2:0] OP_INT     = 3'd1;
    localparam logic [2:0] OP_BSTR    = 3'd2;
    localparam logic [2:0] OP_TSTR    = 3'd3;
    localparam logic [2:0] OP_MAP     = 3'd4;
    localparam logic [2:0] OP_PAYLOAD = 3'd5;
    localparam logic [2:0] OP_BEGIN   = 3'd6;

    // CBOR major types
    localparam logic [2:0] MT_UINT = 3'd0;
    localparam logic [2:0] MT_NINT = 3'd1;
    localparam logic [2:0] MT_MAP  = 3'd5;

    // Additional info codes for 1, 2 and 4 argument bytes
    localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
    localparam logic [4:0] AI_TWO_BYTE  = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTE = 5'd26;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_UNEXP = 2'd2;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // What the back end has to do with a queued command
    typedef enum logic [1:0] {
        K_HEAD,
        K_PAYLOAD,
        K_BEGIN,
        K_NOP
    } t_kind;

    // Classified command, front end to back end
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  hdr;        // initial byte of the head
        logic [31:0] arg;        // head argument
        logic [2:0]  nargs;      // argument bytes after the initial byte: 0, 1, 2 or 4
        logic        is_str;     // head opens a string payload
        logic [7:0]  data_byte;  // payload byte
    } t_cmd;

endpackage

[design/cbie_if.sv]
// Channel interfaces: encoding commands in, encoded bytes out.
interface cbie_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [32:0] value;
    logic [7:0]         data_byte;

    modport source (output valid, output opcode, output value, output data_byte,
                    input ready);
    modport sink   (input valid, input opcode, input value, input data_byte,
                    output ready);
endinterface

interface cbie_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [15:0] out_position;
    logic        byte_valid;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output out_byte, output out_position,
                    output byte_valid, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input out_position,
                    input byte_valid, input status, input last, output ready);
endinterface

[design/cbor_item_head_encoder.sv]
// Top level of the CBOR item head encoder.
//
//  channel     dir  handshake        payload
//  i_in_ch     in   valid/ready      opcode, value, data_byte
//  o_out_ch    out  valid/ready      out_byte, out_position, byte_valid, status, last
//  config      in   i_cfg_we         i_cfg_wdata (buffer capacity)
//
// In the back end, payload, begin and single-byte heads take one step each; a head with
// an argument takes one step per head byte, set by the back end's byte sequencer. The
// front end keeps taking transactions while the command queue
// (QUEUE_DEPTH entries) has room. The output register decouples output stalls.
// Reset is synchronous; after reset the capacity is 65535 and all offsets are zero.
module cbor_item_head_encoder
    import cbie_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    cbie_in_if.sink       i_in_ch,
    cbie_out_if.source    o_out_ch
);

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    cbie_front u_front (
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    cbie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    cbie_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_ch    (o_out_ch)
    );

endmodule

[design/cbie_front.sv]
// Front end: accepts commands and classifies them into head/payload/control work.
module cbie_front
    import cbie_pkg::*;
(
    input  logic          i_rst_n,
    cbie_in_if.sink       i_in_ch,
    input  logic          i_full,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic        neg;
    logic [2:0]  major;
    logic [31:0] arg;

    // Take a transaction whenever the queue has room and reset is not asserted
    assign i_in_ch.ready = !i_full && i_rst_n;
    assign o_push        = i_in_ch.valid && i_in_ch.ready;

    // Major type and argument
    assign neg = i_in_ch.value[32];
    always_comb begin
        major = MT_UINT;
        arg   = i_in_ch.value[31:0];
        unique case (i_in_ch.opcode)
            OP_INT: begin
                major = neg ? MT_NINT : MT_UINT;
                arg   = neg ? ~i_in_ch.value[31:0] : i_in_ch.value[31:0];
            end
            OP_BSTR, OP_TSTR: begin
                major = i_in_ch.opcode;
                arg   = {16'd0, i_in_ch.value[15:0]};
            end
            OP_MAP: begin
                major = MT_MAP;
                arg   = {24'd0, i_in_ch.value[7:0]};
            end
            default: begin
                major = MT_UINT;
                arg   = i_in_ch.value[31:0];
            end
        endcase
    end

    // Head size and initial byte
    always_comb begin
        o_cmd           = '0;
        o_cmd.arg       = arg;
        o_cmd.data_byte = i_in_ch.data_byte;
        o_cmd.is_str    = (i_in_ch.opcode == OP_BSTR) || (i_in_ch.opcode == OP_TSTR);
        priority if (arg < 32'd24) begin
            o_cmd.hdr   = {major, arg[4:0]};
            o_cmd.nargs = 3'd0;
        end else if (arg[31:8] == 24'd0) begin
            o_cmd.hdr   = {major, AI_ONE_BYTE};
            o_cmd.nargs = 3'd1;
        end else if (arg[31:16] == 16'd0) begin
            o_cmd.hdr   = {major, AI_TWO_BYTE};
            o_cmd.nargs = 3'd2;
        end else begin
            o_cmd.hdr   = {major, AI_FOUR_BYTE};
            o_cmd.nargs = 3'd4;
        end
        unique case (i_in_ch.opcode)
            OP_UINT, OP_INT, OP_BSTR, OP_TSTR, OP_MAP: o_cmd.kind = K_HEAD;
            OP_PAYLOAD:                                o_cmd.kind = K_PAYLOAD;
            OP_BEGIN:                                  o_cmd.kind = K_BEGIN;
            default:                                   o_cmd.kind = K_NOP;
        endcase
    end

endmodule

[design/cbie_queue.sv]
// Command queue between front end and back end.
module cbie_queue
    import cbie_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/cbie_back.sv]
// Back end: sequences head bytes and payload bytes against buffer state.
module cbie_back
    import cbie_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    cbie_out_if.source    o_out_ch
);

    logic [15:0] r_cap;
    logic [15:0] r_wo;
    logic [15:0] r_pend;
    logic        r_fits;
    logic [2:0]  r_cnt;
    logic        r_ok;

    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic [15:0] r_pos;
    logic        r_bv;
    logic [1:0]  r_st;
    logic        r_last;

    logic [15:0] n_wo;
    logic [15:0] n_pend;
    logic        n_fits;
    logic [2:0]  n_cnt;
    logic        n_ok;
    logic [7:0]  n_byte;
    logic [15:0] n_pos;
    logic        n_bv;
    logic [1:0]  n_st;

    logic        fire;
    logic        done;
    logic        room;
    logic        ok_cur;
    logic [2:0]  sel;
    logic [7:0]  head_byte;
    logic [16:0] str_end;

    assign fire  = i_cmd_valid && (!r_out_valid || o_out_ch.ready);
    assign done  = (i_cmd.kind != K_HEAD) || (r_cnt == i_cmd.nargs);
    assign o_pop = fire && done;
    assign room  = (r_wo < r_cap);

    // Pick the head byte for this step: initial byte, then argument big-endian
    assign sel = i_cmd.nargs - r_cnt;
    always_comb begin
        if (r_cnt == 3'd0) begin
            head_byte = i_cmd.hdr;
        end else begin
            unique case (sel[1:0])
                2'd0: head_byte = i_cmd.arg[7:0];
                2'd1: head_byte = i_cmd.arg[15:8];
                2'd2: head_byte = i_cmd.arg[23:16];
                default: head_byte = i_cmd.arg[31:24];
            endcase
        end
    end

    assign ok_cur  = ((r_cnt == 3'd0) || r_ok) && room;
    assign str_end = {1'b0, n_wo} + {1'b0, i_cmd.arg[15:0]};

    // Next state and result for one step
    always_comb begin
        n_wo   = r_wo;
        n_pend = r_pend;
        n_fits = r_fits;
        n_cnt  = r_cnt;
        n_ok   = r_ok;
        n_byte = 8'd0;
        n_pos  = r_wo;
        n_bv   = 1'b0;
        n_st   = ST_OK;
        unique case (i_cmd.kind)
            K_HEAD: begin
                if (room) begin
                    n_wo   = r_wo + 16'd1;
                    n_byte = head_byte;
                    n_bv   = 1'b1;
                end else begin
                    n_st = ST_FULL;
                end
                if (done) begin
                    n_cnt  = 3'd0;
                    n_pend = i_cmd.is_str ? i_cmd.arg[15:0] : 16'd0;
                    n_fits = i_cmd.is_str && ok_cur && (str_end <= {1'b0, r_cap});
                end else begin
                    n_cnt = r_cnt + 3'd1;
                    n_ok  = ok_cur;
                end
            end
            K_PAYLOAD: begin
                if (r_pend == 16'd0) begin
                    n_st = ST_UNEXP;
                end else begin
                    n_pend = r_pend - 16'd1;
                    if (r_fits && room) begin
                        n_wo   = r_wo + 16'd1;
                        n_byte = i_cmd.data_byte;
                        n_bv   = 1'b1;
                    end else begin
                        n_st = ST_FULL;
                    end
                end
            end
            K_BEGIN: begin
                n_wo   = 16'd0;
                n_pos  = 16'd0;
                n_pend = 16'd0;
                n_fits = 1'b0;
            end
            default: begin
                n_pend = 16'd0;
                n_fits = 1'b0;
            end
        endcase
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Buffer state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wo   <= '0;
            r_pend <= '0;
            r_fits <= 1'b0;
            r_cnt  <= '0;
            r_ok   <= 1'b0;
        end else if (fire) begin
            r_wo   <= n_wo;
            r_pend <= n_pend;
            r_fits <= n_fits;
            r_cnt  <= n_cnt;
            r_ok   <= n_ok;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= n_byte;
            r_pos  <= n_pos;
            r_bv   <= n_bv;
            r_st   <= n_st;
            r_last <= done;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.out_byte     = r_byte;
    assign o_out_ch.out_position = r_pos;
    assign o_out_ch.byte_valid   = r_bv;
    assign o_out_ch.status       = r_st;
    assign o_out_ch.last         = r_last;

endmodule

[sim/cbor_item_head_encoder_tb.sv]
// Testbench for the CBOR item head encoder: directed table, random command streams, self-checking.
`timescale 1ns / 100ps

module cbor_item_head_encoder_tb
    import cbie_pkg::*;
;

    localparam logic [2:0] OP_RSVD     = 3'd7;  // unused opcode, block encodes it as a no-op with no byte
    localparam int         QUIET_LIMIT = 3000;  // cycles without any transaction
    localparam int         HOLD_CYCLES = 100;   // long receiver hold-off
    localparam int         SETTLE      = 8;     // longest head plus queue slack
    localparam int         PHASE_ITEMS = 14;
    localparam int         N_PHASES    = 6;

    // One encoded byte record as seen on the output channel
    typedef struct packed {
        logic [7:0]  enc_byte;
        logic [15:0] pos;
        logic        byte_valid;
        logic [1:0]  status;
        logic        last;
    } t_enc_rec;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic [2:0]  op;
        logic [32:0] val;
        logic [7:0]  db;
        logic        typed;
        t_enc_rec    want;
    } t_dir_row;

    localparam t_enc_rec NO_REC = '0;
    localparam int DIR_N = 26;

    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{OP_BEGIN,   33'd0,            8'h00, 1'b1, '{8'h00, 16'd0, 1'b0, ST_OK,    1'b1}},
        '{OP_PAYLOAD, 33'd0,            8'hA5, 1'b1, '{8'h00, 16'd0, 1'b0, ST_UNEXP, 1'b1}},
        '{OP_UINT,    33'd0,            8'h00, 1'b1, '{8'h00, 16'd0, 1'b1, ST_OK,    1'b1}},
        '{OP_UINT,    33'd23,           8'hFF, 1'b1, '{8'h17, 16'd1, 1'b1, ST_OK,    1'b1}},
        '{OP_UINT,    33'd24,           8'h00, 1'b0, NO_REC},
        '{OP_UINT,    33'd255,          8'h00, 1'b0, NO_REC},
        '{OP_UINT,    33'd256,          8'h00, 1'b0, NO_REC},
        '{OP_UINT,    33'd65535,        8'h00, 1'b0, NO_REC},
        '{OP_UINT,    33'd65536,        8'h00, 1'b0, NO_REC},
        '{OP_UINT,    33'h0_FFFF_FFFF,  8'h00, 1'b0, NO_REC},
        '{OP_UINT,    33'h1_0000_0000,  8'h00, 1'b0, NO_REC},
        '{OP_INT,     33'h1_FFFF_FFFF,  8'h00, 1'b0, NO_REC},
        '{OP_INT,     33'h1_0000_0000,  8'h00, 1'b0, NO_REC},
        '{OP_INT,     33'h0_FFFF_FFFF,  8'h00, 1'b0, NO_REC},
        '{OP_MAP,     33'd0,            8'h00, 1'b0, NO_REC},
        '{OP_MAP,     33'd255,          8'h00, 1'b0, NO_REC},
        '{OP_MAP,     33'd300,          8'h00, 1'b0, NO_REC},
        '{OP_BSTR,    33'd2,            8'h00, 1'b0, NO_REC},
        '{OP_PAYLOAD, 33'd0,            8'h00, 1'b0, NO_REC},
        '{OP_PAYLOAD, 33'h1_FFFF_FFFF,  8'hFF, 1'b0, NO_REC},
        '{OP_PAYLOAD, 33'd0,            8'h5A, 1'b0, NO_REC},
        '{OP_TSTR,    33'h1_0001_0003,  8'h00, 1'b0, NO_REC},
        '{OP_PAYLOAD, 33'd0,            8'h81, 1'b0, NO_REC},
        '{OP_UINT,    33'd1,            8'h00, 1'b0, NO_REC},
        '{OP_PAYLOAD, 33'd0,            8'h42, 1'b0, NO_REC},
        '{OP_RSVD,    33'h1_FFFF_FFFF,  8'hFF, 1'b0, NO_REC}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    cbie_in_if  in_ch ();
    cbie_out_if out_ch ();

    cbor_item_head_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // Encoder state mirror
    logic [15:0] buf_cap;
    logic [15:0] wr_ofs;
    logic [15:0] str_left;
    logic        str_fits;

    t_enc_rec encoded_q[$];   // bytes still expected on the output
    t_enc_rec step_q[$];      // bytes produced by the current command

    int errors;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_asks;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
        $display("ERR @%0t: %s got 0x%0h want 0x%0h", $time, what, got_v, want_v);
        errors++;
    endtask

    // Store one byte at the write offset, or drop it when the buffer is full
    function automatic bit store_enc(input logic [7:0] b);
        if (wr_ofs >= buf_cap) begin
            step_q.push_back('{8'h00, wr_ofs, 1'b0, ST_FULL, 1'b0});
            return 1'b0;
        end
        step_q.push_back('{b, wr_ofs, 1'b1, ST_OK, 1'b0});
        wr_ofs = wr_ofs + 16'd1;
        return 1'b1;
    endfunction

    // Bytes produced by one command, into step_q
    function automatic void encode_cmd(input logic [2:0] op, input logic [32:0] val,
                                       input logic [7:0] db);
        logic [2:0]  major;
        logic [31:0] arg;
        logic [7:0]  hdr;
        int          nargs;
        bit          ok;
        t_enc_rec    tail;
        step_q.delete();
        ok = 1'b1;
        major = MT_UINT;
        arg = '0;
        if (op == OP_PAYLOAD) begin
            if (str_left == 16'd0) begin
                step_q.push_back('{8'h00, wr_ofs, 1'b0, ST_UNEXP, 1'b0});
            end else begin
                str_left = str_left - 16'd1;
                if (str_fits)
                    void'(store_enc(db));
                else
                    step_q.push_back('{8'h00, wr_ofs, 1'b0, ST_FULL, 1'b0});
            end
        end else if (op == OP_BEGIN || op == OP_RSVD) begin
            // any non-payload command abandons a pending string
            str_left = 16'd0;
            str_fits = 1'b0;
            if (op == OP_BEGIN)
                wr_ofs = 16'd0;
            step_q.push_back('{8'h00, wr_ofs, 1'b0, ST_OK, 1'b0});
        end else begin
            str_left = 16'd0;
            str_fits = 1'b0;
            case (op)
                OP_UINT: begin
                    major = MT_UINT;
                    arg = val[31:0];
                end
                OP_INT: begin
                    // negative n is coded as major 1 with -1-n
                    major = val[32] ? MT_NINT : MT_UINT;
                    arg = val[32] ? ~val[31:0] : val[31:0];
                end
                OP_BSTR, OP_TSTR: begin
                    major = op;
                    arg = {16'h0000, val[15:0]};
                end
                default: begin
                    major = MT_MAP;
                    arg = {24'h000000, val[7:0]};
                end
            endcase
            // initial byte then big-endian argument bytes
            if (arg < 32'(AI_ONE_BYTE)) begin
                hdr = {major, arg[4:0]};
                nargs = 0;
            end else if (arg <= 32'h0000_00FF) begin
                hdr = {major, AI_ONE_BYTE};
                nargs = 1;
            end else if (arg <= 32'h0000_FFFF) begin
                hdr = {major, AI_TWO_BYTE};
                nargs = 2;
            end else begin
                hdr = {major, AI_FOUR_BYTE};
                nargs = 4;
            end
            if (!store_enc(hdr))
                ok = 1'b0;
            for (int i = nargs - 1; i >= 0; i--) begin
                if (!store_enc(arg[8*i +: 8]))
                    ok = 1'b0;
            end
            if (op == OP_BSTR || op == OP_TSTR) begin
                str_left = arg[15:0];
                str_fits = ok && ((32'(wr_ofs) + arg) <= 32'(buf_cap));
            end
        end
        tail = step_q.pop_back();
        tail.last = 1'b1;
        step_q.push_back(tail);
    endfunction

    // Offer one command; valid stays high across back-to-back transactions
    task automatic send_cmd(input logic [2:0] op, input logic [32:0] val,
                            input logic [7:0] db, input logic typed, input t_enc_rec want);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.value     <= val;
        in_ch.data_byte <= db;
        do @(posedge i_clk); while (!in_ch.ready);
        encode_cmd(op, val, db);
        if (typed)
            encoded_q.push_back(want);
        else
            foreach (step_q[k]) encoded_q.push_back(step_q[k]);
    endtask

    // Stop offering and wait until every expected byte has arrived
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        while (encoded_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        buf_cap = cap;
    endtask

    // Random command stream: string heads with their payload, integer and map heads, begins and noise
    task automatic run_random(input int n_items);
        int          sent;
        int          pick;
        int          len;
        int          n_pay;
        logic [32:0] val;
        logic [2:0]  op;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            val = {1'($urandom_range(0, 1)), 32'($urandom)};
            if (pick < 10) begin
                send_cmd(OP_BEGIN, val, 8'($urandom), 1'b0, NO_REC);
                sent++;
            end else if (pick < 45) begin
                // string head; payload count sometimes one short or one too many
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 5);
                val[15:0] = 16'(len);
                op = ($urandom_range(0, 1) != 0) ? OP_TSTR : OP_BSTR;
                send_cmd(op, val, 8'($urandom), 1'b0, NO_REC);
                sent++;
                n_pay = (len > 6) ? $urandom_range(0, 4) : len;
                pick = $urandom_range(0, 9);
                if (pick == 0 && n_pay > 0)
                    n_pay--;
                else if (pick == 1)
                    n_pay++;
                repeat (n_pay) begin
                    send_cmd(OP_PAYLOAD, {1'($urandom_range(0, 1)), 32'($urandom)},
                             8'($urandom), 1'b0, NO_REC);
                    sent++;
                end
            end else if (pick < 80) begin
                // integer or map head across all argument sizes
                case ($urandom_range(0, 4))
                    0: val = 33'($urandom_range(0, 23));
                    1: val = 33'($urandom_range(24, 255));
                    2: val = 33'($urandom_range(256, 65535));
                    3: val = {1'b0, 32'($urandom)};
                    default: ;
                endcase
                pick = $urandom_range(0, 2);
                op = (pick == 0) ? OP_UINT : (pick == 1) ? OP_INT : OP_MAP;
                if (op == OP_INT && $urandom_range(0, 1) != 0)
                    val = ~val;
                send_cmd(op, val, 8'($urandom), 1'b0, NO_REC);
                sent++;
            end else begin
                send_cmd(3'($urandom_range(0, 7)), val, 8'($urandom), 1'b0, NO_REC);
                sent++;
            end
        end
    endtask

    // Receiver: random stalls plus an occasional long hold-off
    initial begin : sink_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Output checker and watchdog
    always @(posedge i_clk) begin : out_check
        t_enc_rec got;
        t_enc_rec want;
        int       quiet;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_byte, out_ch.out_position, out_ch.byte_valid,
                    out_ch.status, out_ch.last};
            if (encoded_q.size() == 0) begin
                flag_mismatch("result with nothing expected, position", got.pos, 0);
            end else begin
                want = encoded_q.pop_front();
                if (got.enc_byte != want.enc_byte)
                    flag_mismatch("out_byte", got.enc_byte, want.enc_byte);
                if (got.pos != want.pos)
                    flag_mismatch("out_position", got.pos, want.pos);
                if (got.byte_valid != want.byte_valid)
                    flag_mismatch("byte_valid", got.byte_valid, want.byte_valid);
                if (got.status != want.status)
                    flag_mismatch("status", got.status, want.status);
                if (got.last != want.last)
                    flag_mismatch("last", got.last, want.last);
            end
        end
        if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] cap;
        errors = 0;
        hold_asks = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'h0000;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_BEGIN;
        in_ch.value = '0;
        in_ch.data_byte = 8'h00;
        buf_cap = CAPACITY_RESET;
        wr_ofs = 16'd0;
        str_left = 16'd0;
        str_fits = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at reset capacity
        for (int r = 0; r < DIR_N; r++)
            send_cmd(DIR_TAB[r].op, DIR_TAB[r].val, DIR_TAB[r].db, DIR_TAB[r].typed,
                     DIR_TAB[r].want);
        drain_outputs();

        // Capacity lowered while a string payload is pending
        set_capacity(16'hFFFF);
        send_cmd(OP_BEGIN, 33'd0, 8'h00, 1'b0, NO_REC);
        send_cmd(OP_BSTR, 33'd4, 8'h00, 1'b0, NO_REC);
        send_cmd(OP_PAYLOAD, 33'd0, 8'h11, 1'b0, NO_REC);
        send_cmd(OP_PAYLOAD, 33'd0, 8'h22, 1'b0, NO_REC);
        drain_outputs();
        set_capacity(16'd3);
        send_cmd(OP_PAYLOAD, 33'd0, 8'h33, 1'b0, NO_REC);
        send_cmd(OP_PAYLOAD, 33'd0, 8'h44, 1'b0, NO_REC);

        // Random phases: capacity setting and idling pattern change per phase
        for (int p = 0; p < N_PHASES; p++) begin
            drain_outputs();
            case (p)
                0: cap = 16'hFFFF;
                1: cap = 16'h0000;
                2: cap = 16'd1;
                3: cap = 16'd24;
                4: cap = 16'($urandom_range(30, 400));
                default: cap = 16'hFFFF;
            endcase
            set_capacity(cap);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
                default: begin src_idle_pct = 22; snk_stall_pct = 22; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 0)
                hold_asks++;
            if (p == 2) begin
                run_random(PHASE_ITEMS / 2);
                drain_outputs();
                run_random(PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end

        drain_outputs();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[cbor_item_head_encoder.f]
design/cbie_pkg.sv
design/cbie_if.sv
design/cbie_front.sv
design/cbie_queue.sv
design/cbie_back.sv
design/cbor_item_head_encoder.sv
sim/cbor_item_head_encoder_tb.sv
